// ===== hdl/opdcs_pkg.sv =====
`default_nettype none

package opdcs_pkg;

    // Field widths of a request and of a command beat.
    localparam int ADDR_W = 32;
    localparam int COL_W  = 12;
    localparam int ROW_W  = ADDR_W - COL_W;
    localparam int TIM_W  = 8;

    // Configuration port geometry: six 8-bit registers at a 4-byte stride.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 3;

    // Default depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Register indexes, in address order.
    localparam logic [REG_IDX_W-1:0] REG_ACT_TO_ACC   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRE_TO_ACT   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_ACTIVE   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RD_TO_PRE    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RD_TO_WR     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROW_HIT_GAP  = 3'd5;

    // Register reset values.
    localparam logic [TIM_W-1:0] RST_ACT_TO_ACC  = 8'd12;
    localparam logic [TIM_W-1:0] RST_PRE_TO_ACT  = 8'd20;
    localparam logic [TIM_W-1:0] RST_MIN_ACTIVE  = 8'd19;
    localparam logic [TIM_W-1:0] RST_RD_TO_PRE   = 8'd3;
    localparam logic [TIM_W-1:0] RST_RD_TO_WR    = 8'd4;
    localparam logic [TIM_W-1:0] RST_ROW_HIT_GAP = 8'd1;

    typedef enum logic [1:0] {
        CMD_PRECHARGE = 2'd0,
        CMD_ACTIVATE  = 2'd1,
        CMD_READ      = 2'd2,
        CMD_WRITE     = 2'd3
    } t_cmd;

    // Sequencer step of the back end, one-hot.
    typedef enum logic [2:0] {
        PH_PRE = 3'b001,
        PH_ACT = 3'b010,
        PH_ACC = 3'b100
    } t_phase;

    // Timing registers as seen by the front end.
    typedef struct packed {
        logic [TIM_W-1:0] act_to_acc;
        logic [TIM_W-1:0] pre_to_act;
        logic [TIM_W-1:0] min_active;
        logic [TIM_W-1:0] rd_to_pre;
        logic [TIM_W-1:0] rd_to_wr;
        logic [TIM_W-1:0] row_hit_gap;
    } t_cfg;

    // One classified request: everything the back end needs to issue it.
    typedef struct packed {
        logic             pre_en;
        logic [TIM_W-1:0] pre_idle;
        logic             act_en;
        logic [TIM_W-1:0] act_idle;
        logic [ROW_W-1:0] row;
        logic             wr;
        logic [TIM_W-1:0] acc_idle;
        logic [COL_W-1:0] col;
    } t_plan;

    // Idle cycles ahead of a command: the delay minus one, floored at zero.
    function automatic logic [TIM_W-1:0] idle_of(input logic [TIM_W-1:0] delay);
        logic [TIM_W-1:0] res;
        res = (delay == '0) ? '0 : delay - TIM_W'(1);
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/opdcs_if.sv =====
`default_nettype none

// Request channel: one load or store per beat.
interface opdcs_req_if
    import opdcs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output req_type, output address, input ready);
    modport sink   (input valid, input req_type, input address, output ready);
endinterface

// Command channel: one memory command per beat.
interface opdcs_cmd_if
    import opdcs_pkg::*;
();
    logic             valid;
    logic             ready;
    t_cmd             command;
    logic [TIM_W-1:0] idle_cycles;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             last;

    modport source (output valid, output command, output idle_cycles, output row,
                    output column, output last, input ready);
    modport sink   (input valid, input command, input idle_cycles, input row,
                    input column, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/opdcs_front.sv =====
`default_nettype none

module opdcs_front
    import opdcs_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    opdcs_req_if.sink   i_req,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_full,
    output t_plan       o_plan,
    output logic        o_push
);

    // Bank state as left by the last accepted request.
    logic [ROW_W-1:0] r_open_row, n_open_row;
    logic             r_row_open, n_row_open;
    logic             r_last_wr,  n_last_wr;
    logic [TIM_W-1:0] r_active,   n_active;

    logic [ROW_W-1:0] row_in;
    logic [COL_W-1:0] col_in;
    logic             miss;
    logic [TIM_W-1:0] pre_base;
    logic [TIM_W-1:0] pre_delay;
    logic [TIM_W-1:0] hit_delay;
    logic [TIM_W-1:0] acc_delay;
    logic [TIM_W-1:0] act_base;
    logic [TIM_W-1:0] act_inc;
    logic [TIM_W:0]   act_sum;

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    assign row_in = i_req.address[ADDR_W-1:COL_W];
    assign col_in = i_req.address[COL_W-1:0];
    assign miss   = !r_row_open || (row_in != r_open_row);

    // Precharge waits out the minimum active time, and after a read also
    // the read-to-precharge gap.
    always_comb begin
        pre_base  = (i_cfg.min_active > r_active) ? i_cfg.min_active - r_active : '0;
        pre_delay = (!r_last_wr && pre_base < i_cfg.rd_to_pre) ? i_cfg.rd_to_pre : pre_base;
        hit_delay = (i_req.req_type && !r_last_wr) ? i_cfg.rd_to_wr : i_cfg.row_hit_gap;
        acc_delay = miss ? i_cfg.act_to_acc : hit_delay;
    end

    // Active-cycle counter: cleared by a precharge, then grows by one for
    // the activate or by the access gap on a row hit, saturating.
    always_comb begin
        act_base = (miss && r_row_open) ? '0 : r_active;
        act_inc  = miss ? TIM_W'(1) : hit_delay;
        act_sum  = {1'b0, act_base} + {1'b0, act_inc};
    end

    // Classified request handed to the queue.
    always_comb begin
        o_plan.pre_en   = miss && r_row_open;
        o_plan.pre_idle = idle_of(pre_delay);
        o_plan.act_en   = miss;
        o_plan.act_idle = r_row_open ? idle_of(i_cfg.pre_to_act) : '0;
        o_plan.row      = row_in;
        o_plan.wr       = i_req.req_type;
        o_plan.acc_idle = idle_of(acc_delay);
        o_plan.col      = col_in;
    end

    always_comb begin
        n_open_row = r_open_row;
        n_row_open = r_row_open;
        n_last_wr  = r_last_wr;
        n_active   = r_active;
        if (o_push) begin
            n_open_row = row_in;
            n_row_open = 1'b1;
            n_last_wr  = i_req.req_type;
            n_active   = act_sum[TIM_W] ? '1 : act_sum[TIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_row <= '0;
            r_row_open <= 1'b0;
            r_last_wr  <= 1'b0;
            r_active   <= '0;
        end else begin
            r_open_row <= n_open_row;
            r_row_open <= n_row_open;
            r_last_wr  <= n_last_wr;
            r_active   <= n_active;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/opdcs_queue.sv =====
`default_nettype none

module opdcs_queue
    import opdcs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_plan i_plan,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_empty,
    output t_plan      o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_plan            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Circular pointers and fill count.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_plan;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/opdcs_back.sv =====
`default_nettype none

module opdcs_back
    import opdcs_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_empty,
    input  wire t_plan  i_head,
    output logic        o_pop,
    opdcs_cmd_if.source o_cmd
);

    t_phase           r_phase, n_phase;
    t_phase           step;
    logic             load;
    logic             fire;

    logic             r_valid, n_valid;
    t_cmd             r_command, n_command;
    logic [TIM_W-1:0] r_idle, n_idle;
    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic             r_last, n_last;

    assign o_cmd.valid       = r_valid;
    assign o_cmd.command     = r_command;
    assign o_cmd.idle_cycles = r_idle;
    assign o_cmd.row         = r_row;
    assign o_cmd.column      = r_col;
    assign o_cmd.last        = r_last;

    // The output register takes a new beat when empty or being drained.
    assign load = !r_valid || o_cmd.ready;
    assign fire = load && !i_empty;

    // Skip the steps the head request does not need.
    always_comb begin
        case (r_phase)
            PH_PRE:  step = i_head.pre_en ? PH_PRE : (i_head.act_en ? PH_ACT : PH_ACC);
            PH_ACT:  step = PH_ACT;
            PH_ACC:  step = PH_ACC;
            default: step = PH_ACC;
        endcase
    end

    assign o_pop = fire && (step == PH_ACC);

    always_comb begin
        n_phase   = r_phase;
        n_valid   = r_valid;
        n_command = r_command;
        n_idle    = r_idle;
        n_row     = r_row;
        n_col     = r_col;
        n_last    = r_last;
        if (load) begin
            n_valid = fire;
        end
        if (fire) begin
            case (step)
                PH_PRE: begin
                    n_command = CMD_PRECHARGE;
                    n_idle    = i_head.pre_idle;
                    n_row     = '0;
                    n_col     = '0;
                    n_last    = 1'b0;
                    n_phase   = PH_ACT;
                end
                PH_ACT: begin
                    n_command = CMD_ACTIVATE;
                    n_idle    = i_head.act_idle;
                    n_row     = i_head.row;
                    n_col     = '0;
                    n_last    = 1'b0;
                    n_phase   = PH_ACC;
                end
                default: begin
                    n_command = i_head.wr ? CMD_WRITE : CMD_READ;
                    n_idle    = i_head.acc_idle;
                    n_row     = '0;
                    n_col     = i_head.col;
                    n_last    = 1'b1;
                    n_phase   = PH_PRE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PRE;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_command <= n_command;
        r_idle    <= n_idle;
        r_row     <= n_row;
        r_col     <= n_col;
        r_last    <= n_last;
    end

endmodule

`default_nettype wire

// ===== hdl/open_page_dram_command_scheduler.sv =====
// Open-page command scheduler for a single bank. Each request beat (load or
// store with a byte address; row in bits 31..12, column in bits 11..0) turns
// into one to three command beats: a precharge when another row is open, an
// activate on a row miss, and always the read or write, which carries last.
// Every command states the idle cycles to insert ahead of it, taken from the
// six 8-bit timing registers on the APB port (byte address 4*index). A front
// end classifies each request the cycle it is accepted and writes it to a
// small queue; a back end issues one command per cycle from it through a
// registered output, while that output is not stalled. Requests are
// taken every cycle while the queue has room. The user must write the
// timing registers only while no request is in flight; the block itself
// does not enforce it.
`default_nettype none

module open_page_dram_command_scheduler
    import opdcs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    opdcs_req_if.sink               i_req,
    opdcs_cmd_if.source             o_cmd,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    t_cfg                 r_cfg, n_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;
    logic [TIM_W-1:0]     rd_val;

    t_plan plan;
    t_plan head;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;

    // Configuration port: no wait states.
    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_ACT_TO_ACC:  n_cfg.act_to_acc  = pwdata[TIM_W-1:0];
                REG_PRE_TO_ACT:  n_cfg.pre_to_act  = pwdata[TIM_W-1:0];
                REG_MIN_ACTIVE:  n_cfg.min_active  = pwdata[TIM_W-1:0];
                REG_RD_TO_PRE:   n_cfg.rd_to_pre   = pwdata[TIM_W-1:0];
                REG_RD_TO_WR:    n_cfg.rd_to_wr    = pwdata[TIM_W-1:0];
                REG_ROW_HIT_GAP: n_cfg.row_hit_gap = pwdata[TIM_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (reg_idx)
            REG_ACT_TO_ACC:  rd_val = r_cfg.act_to_acc;
            REG_PRE_TO_ACT:  rd_val = r_cfg.pre_to_act;
            REG_MIN_ACTIVE:  rd_val = r_cfg.min_active;
            REG_RD_TO_PRE:   rd_val = r_cfg.rd_to_pre;
            REG_RD_TO_WR:    rd_val = r_cfg.rd_to_wr;
            REG_ROW_HIT_GAP: rd_val = r_cfg.row_hit_gap;
            default:         rd_val = '0;
        endcase
    end

    assign prdata = {{(PDATA_W-TIM_W){1'b0}}, rd_val};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.act_to_acc  <= RST_ACT_TO_ACC;
            r_cfg.pre_to_act  <= RST_PRE_TO_ACT;
            r_cfg.min_active  <= RST_MIN_ACTIVE;
            r_cfg.rd_to_pre   <= RST_RD_TO_PRE;
            r_cfg.rd_to_wr    <= RST_RD_TO_WR;
            r_cfg.row_hit_gap <= RST_ROW_HIT_GAP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Request classification and bank state.
    opdcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cfg   (r_cfg),
        .i_full  (full),
        .o_plan  (plan),
        .o_push  (push)
    );

    // Decoupling queue between classification and command issue.
    opdcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_plan  (plan),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // Command sequencer and output register.
    opdcs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_cmd   (o_cmd)
    );

endmodule

`default_nettype wire

// ===== hdl/opdcs_checker.sv =====
`default_nettype none

module opdcs_checker
    import opdcs_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_cmd_valid,
    input wire logic             i_cmd_ready,
    input wire logic [1:0]       i_cmd_command,
    input wire logic [TIM_W-1:0] i_cmd_idle,
    input wire logic [ROW_W-1:0] i_cmd_row,
    input wire logic [COL_W-1:0] i_cmd_column,
    input wire logic             i_cmd_last,
    input wire logic             i_pready
);

    // A stalled command beat holds its payload.
    a_cmd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && !i_cmd_ready |=> i_cmd_valid && $stable(i_cmd_command)
            && $stable(i_cmd_idle) && $stable(i_cmd_row) && $stable(i_cmd_column))
        else $error("command beat changed while stalled");

    // Only the read or write closes a request.
    a_last_on_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid |-> (i_cmd_last == i_cmd_command[1]))
        else $error("last flag does not match command kind");

    // Row is carried only by an activate, column only by an access.
    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid |-> (i_cmd_command == CMD_ACTIVATE || i_cmd_row == '0)
            && (i_cmd_command[1] || i_cmd_column == '0))
        else $error("unused address field not zero");

    // A precharge beat is always followed directly by the activate of the
    // same request.
    a_pre_then_act: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready && i_cmd_command == CMD_PRECHARGE
            ##1 i_cmd_valid |-> i_cmd_command == CMD_ACTIVATE)
        else $error("precharge not followed by activate");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) i_pready)
        else $error("pready dropped");

endmodule

bind open_page_dram_command_scheduler opdcs_checker u_opdcs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cmd_valid   (o_cmd.valid),
    .i_cmd_ready   (o_cmd.ready),
    .i_cmd_command (o_cmd.command),
    .i_cmd_idle    (o_cmd.idle_cycles),
    .i_cmd_row     (o_cmd.row),
    .i_cmd_column  (o_cmd.column),
    .i_cmd_last    (o_cmd.last),
    .i_pready      (pready)
);

`default_nettype wire
